// ----- hw/rtl/line_pixel_rasterizer_defines.svh -----
// Assertion helpers for the line rasterizer.
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define LPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/lpr_pkg.sv -----
`default_nettype none

package lpr_pkg;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} lpr_req_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
	} lpr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
	} lpr_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpr_ctrl.sv -----
`default_nettype none

module lpr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                req_type,
	input  logic                out_stall,
	input  lpr_pkg::lpr_status_t status,
	output logic                in_stall,
	output logic                out_valid,
	output logic                line_active,
	output lpr_pkg::lpr_cmd_t   cmd
);
	import lpr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_ACTIVE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// output register full and not drained this cycle
	assign in_stall    = out_valid_q && out_stall;
	assign accept      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign line_active = (state_q == ST_ACTIVE);

	always_comb begin
		cmd.load = accept && (req_type == REQ_START);
		cmd.step = accept && (req_type == REQ_STEP) && (state_q == ST_ACTIVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_ACTIVE;
				end
				ST_ACTIVE: begin
					if (cmd.load) state_q <= ST_ACTIVE;
					else if (cmd.step && status.last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.step) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lpr_datapath.sv -----
`default_nettype none

module lpr_datapath #(
	parameter int unsigned ROW_SHIFT = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpr_pkg::lpr_cmd_t    cmd,
	output lpr_pkg::lpr_status_t status,
	input  logic                 cfg_valid,
	input  logic [31:0]          cfg_data,
	input  logic [8:0]           x_start,
	input  logic [7:0]           y_start,
	input  logic [8:0]           x_end,
	input  logic [7:0]           y_end,
	input  logic [15:0]          colour,
	output logic [8:0]           pixel_x,
	output logic [7:0]           pixel_y,
	output logic [31:0]          pixel_address,
	output logic [15:0]          pixel_colour,
	output logic                 last_pixel
);
	import lpr_pkg::*;

	logic [31:0] frame_base_q;

	// line state
	logic               steep_q;
	logic [8:0]         major_pos_q;
	logic [8:0]         major_end_q;
	logic [8:0]         minor_q;
	logic [8:0]         dmaj_q;
	logic signed [9:0]  dmin_q;
	logic signed [10:0] rem_q;
	logic [15:0]        colour_q;

	// output register
	logic [8:0]  pixel_x_q;
	logic [7:0]  pixel_y_q;
	logic [31:0] pixel_address_q;
	logic [15:0] pixel_colour_q;
	logic        last_pixel_q;

	// start decode
	logic [8:0]        adx;
	logic [7:0]        ady;
	logic              steep;
	logic [8:0]        a0, a1, n0, n1;
	logic              swap;
	logic [8:0]        ma0, ma1, mi0, mi1;
	logic signed [9:0] dmin;

	// step
	logic               last;
	logic [8:0]         px;
	logic [7:0]         py;
	logic [31:0]        addr;
	logic signed [10:0] rem_sum;
	logic signed [10:0] dmaj_ext;
	logic signed [10:0] rem_n;
	logic [8:0]         minor_n;

	always_comb begin
		adx   = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
		ady   = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
		steep = ({1'b0, ady} > adx);
		a0    = steep ? {1'b0, y_start} : x_start;
		a1    = steep ? {1'b0, y_end}   : x_end;
		n0    = steep ? x_start : {1'b0, y_start};
		n1    = steep ? x_end   : {1'b0, y_end};
		swap  = (a0 > a1);
		ma0   = swap ? a1 : a0;
		ma1   = swap ? a0 : a1;
		mi0   = swap ? n1 : n0;
		mi1   = swap ? n0 : n1;
		dmin  = $signed({1'b0, mi1}) - $signed({1'b0, mi0});
	end

	always_comb begin
		last = (major_pos_q >= major_end_q);
		px   = steep_q ? minor_q : major_pos_q;
		py   = steep_q ? major_pos_q[7:0] : minor_q[7:0];
		addr = frame_base_q + ({24'b0, py} << ROW_SHIFT) + {22'b0, px, 1'b0};

		// remainder of offset*dmin/dmaj stays in [0, dmaj); |dmin| <= dmaj
		dmaj_ext = $signed({2'b00, dmaj_q});
		rem_sum  = rem_q + {dmin_q[9], dmin_q};
		rem_n    = rem_sum;
		minor_n  = minor_q;
		if (rem_sum < 0) begin
			rem_n   = rem_sum + dmaj_ext;
			minor_n = minor_q - 9'd1;
		end else if (rem_sum >= dmaj_ext) begin
			rem_n   = rem_sum - dmaj_ext;
			minor_n = minor_q + 9'd1;
		end
	end

	assign status.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= 32'd0;
		end else if (cfg_valid) begin
			frame_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			steep_q     <= steep;
			major_pos_q <= ma0;
			major_end_q <= ma1;
			minor_q     <= mi0;
			dmaj_q      <= ma1 - ma0;
			dmin_q      <= dmin;
			rem_q       <= '0;
			colour_q    <= colour;
		end else if (cmd.step) begin
			major_pos_q <= major_pos_q + 9'd1;
			minor_q     <= minor_n;
			rem_q       <= rem_n;
		end

		if (cmd.step) begin
			pixel_x_q       <= px;
			pixel_y_q       <= py;
			pixel_address_q <= addr;
			pixel_colour_q  <= colour_q;
			last_pixel_q    <= last;
		end
	end

	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign pixel_address = pixel_address_q;
	assign pixel_colour  = pixel_colour_q;
	assign last_pixel    = last_pixel_q;

endmodule

`default_nettype wire

// ----- hw/rtl/line_pixel_rasterizer.sv -----
// A step beat's pixel is registered when the beat is accepted and appears on the output in the cycle after.
// One beat per cycle while in_stall is low; the datapath handles each start or step beat as it is accepted.
// Input stalls only while the pixel output register is full and held by out_stall.
// Reset clears the line (idle), the output valid and frame_base to zero.
`default_nettype none

`include "line_pixel_rasterizer_defines.svh"

module line_pixel_rasterizer #(
	parameter int unsigned ROW_SHIFT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [8:0]  x_start,
	input  logic [7:0]  y_start,
	input  logic [8:0]  x_end,
	input  logic [7:0]  y_end,
	input  logic [15:0] colour,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [31:0] pixel_address,
	output logic [15:0] pixel_colour,
	output logic        last_pixel
);
	import lpr_pkg::*;

	lpr_cmd_t    cmd;
	lpr_status_t status;
	logic        line_active;

	assign cfg_ready = 1'b1;

	lpr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.out_stall   (out_stall),
		.status      (status),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.line_active (line_active),
		.cmd         (cmd)
	);

	lpr_datapath #(
		.ROW_SHIFT (ROW_SHIFT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.x_start       (x_start),
		.y_start       (y_start),
		.x_end         (x_end),
		.y_end         (y_end),
		.colour        (colour),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_colour  (pixel_colour),
		.last_pixel    (last_pixel)
	);

	// a start beat never produces a pixel
	`LPR_ASSERT_NEXT(a_start_no_pixel, clk, arst_n, in_valid && !in_stall && (req_type == REQ_START), !out_valid, "start beat produced a pixel")
	// once the last pixel leaves, the line is over
	`LPR_ASSERT_NEXT(a_last_ends_line, clk, arst_n, out_valid && last_pixel && !out_stall, !out_valid, "pixel after end of line")
	`LPR_ASSERT_IMP(a_last_idle, clk, arst_n, out_valid && last_pixel, !line_active || !$stable(line_active) || !out_stall, "line still active after last pixel")
	`LPR_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with output free")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	localparam int unsigned ROW_SHIFT = 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [8:0]  x;
		logic [7:0]  y;
		logic [31:0] addr;
		logic [15:0] col;
		logic        last;
	} pixel_t;

	// Tracks the line walk and queues the pixels the block owes us.
	class pixel_scoreboard;
		logic [31:0] frame_base;
		bit          active;
		bit          steep;
		logic [8:0]  major_at;
		logic [8:0]  major_stop;
		logic [8:0]  major_first;
		logic [8:0]  minor_first;
		int          major_span;
		int          minor_span;
		logic [15:0] line_col;
		pixel_t      pending_pixels[$];
		int          errors;

		function new();
			frame_base = '0;
			active = 1'b0;
			steep = 1'b0;
			major_at = '0;
			major_stop = '0;
			major_first = '0;
			minor_first = '0;
			major_span = 0;
			minor_span = 0;
			line_col = '0;
			errors = 0;
		endfunction

		// Returns 1 when the beat does something (start, or step on an active line).
		function bit note_beat(lpr_req_t req, logic [8:0] xs, logic [7:0] ys,
				logic [8:0] xe, logic [7:0] ye, logic [15:0] col);
			int x0, y0, x1, y1, adx, ady, a0, a1, i0, i1, t;
			longint offs, num, den, q, minor;
			pixel_t p;
			if (req == REQ_START) begin
				x0 = int'(xs);
				y0 = int'(ys);
				x1 = int'(xe);
				y1 = int'(ye);
				adx = (x1 > x0) ? x1 - x0 : x0 - x1;
				ady = (y1 > y0) ? y1 - y0 : y0 - y1;
				steep = ady > adx;
				if (steep) begin
					a0 = y0; a1 = y1; i0 = x0; i1 = x1;
				end else begin
					a0 = x0; a1 = x1; i0 = y0; i1 = y1;
				end
				if (a0 > a1) begin
					t = a0; a0 = a1; a1 = t;
					t = i0; i0 = i1; i1 = t;
				end
				major_first = 9'(a0);
				major_at = 9'(a0);
				major_stop = 9'(a1);
				minor_first = 9'(i0);
				major_span = a1 - a0;
				minor_span = i1 - i0;
				line_col = col;
				active = 1'b1;
				return 1'b1;
			end
			if (!active)
				return 1'b0;
			offs = longint'(major_at) - longint'(major_first);
			num = offs * longint'(minor_span);
			den = longint'(major_span);
			// floor division, rounding toward minus infinity
			if (den <= 0)
				q = 0;
			else if (num >= 0)
				q = num / den;
			else
				q = -((-num + den - 1) / den);
			minor = longint'(minor_first) + q;
			if (minor < 0)
				minor = 0;
			if (steep) begin
				p.x = minor[8:0];
				p.y = major_at[7:0];
			end else begin
				p.x = major_at;
				p.y = minor[7:0];
			end
			p.addr = frame_base + ({24'd0, p.y} << ROW_SHIFT) + ({23'd0, p.x} << 1);
			p.col = line_col;
			p.last = (major_at >= major_stop);
			pending_pixels.push_back(p);
			if (p.last)
				active = 1'b0;
			else
				major_at = major_at + 9'd1;
			return 1'b1;
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected pixel, expected none, actual x=%0d y=%0d addr=%0h",
					$time, got.x, got.y, got.addr);
				return;
			end
			want = pending_pixels.pop_front();
			field_check("pixel_x", 32'(want.x), 32'(got.x));
			field_check("pixel_y", 32'(want.y), 32'(got.y));
			field_check("pixel_address", want.addr, got.addr);
			field_check("pixel_colour", 32'(want.col), 32'(got.col));
			field_check("last_pixel", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [8:0]  x_start = '0;
	logic [7:0]  y_start = '0;
	logic [8:0]  x_end = '0;
	logic [7:0]  y_end = '0;
	logic [15:0] colour = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [31:0] pixel_address;
	logic [15:0] pixel_colour;
	logic        last_pixel;

	pixel_scoreboard sb;
	int send_idle = 0;
	int recv_idle = 0;
	logic stall_hold = 1'b0;
	int useful = 0;
	int cycles = 0;

	line_pixel_rasterizer #(.ROW_SHIFT(ROW_SHIFT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.colour(colour),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.pixel_colour(pixel_colour),
		.last_pixel(last_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= stall_hold || ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel({pixel_x, pixel_y, pixel_address, pixel_colour, last_pixel});
	end

	task automatic send_beat(lpr_req_t req, logic [8:0] xs, logic [7:0] ys,
			logic [8:0] xe, logic [7:0] ye, logic [15:0] col);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		colour <= col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sb.note_beat(req, xs, ys, xe, ye, col))
			useful++;
	endtask

	// step beats carry junk in the unused fields
	task automatic step_n(int n);
		repeat (n)
			send_beat(REQ_STEP, 9'($urandom_range(511)), 8'($urandom_range(255)),
				9'($urandom_range(511)), 8'($urandom_range(255)),
				16'($urandom_range(65535)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(logic [31:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.frame_base = v;
	endtask

	function automatic int near(int v, int span, int hi);
		int t;
		t = v + int'($urandom_range(2 * span)) - span;
		return (t < 0) ? 0 : (t > hi) ? hi : t;
	endfunction

	task automatic random_sequence();
		int kind, xs, ys, xe, ye, span, adx, ady, dmaj, n, r;
		kind = $urandom_range(199);
		xs = $urandom_range(511);
		ys = $urandom_range(255);
		if ($urandom_range(9) == 0)
			xs = $urandom_range(1) ? 511 : 0;
		if ($urandom_range(9) == 0)
			ys = $urandom_range(1) ? 255 : 0;
		if (kind >= 18 && kind < 30) begin
			// loose steps: continue a cut-off line or hit an idle block
			step_n($urandom_range(1, 3));
			return;
		end
		if (kind < 8) begin
			xe = $urandom_range(511);
			ye = $urandom_range(255);
		end else if (kind < 18) begin
			xe = xs;
			ye = ys;
		end else begin
			span = $urandom_range(1, 15);
			xe = near(xs, span, 511);
			ye = near(ys, span, 255);
		end
		adx = (xe > xs) ? xe - xs : xs - xe;
		ady = (ye > ys) ? ye - ys : ys - ye;
		dmaj = (ady > adx) ? ady : adx;
		n = dmaj + 1;
		r = $urandom_range(99);
		if (kind >= 2 && kind < 8)
			n = $urandom_range(1, 24);
		else if (kind >= 8 && r < 15 && dmaj > 0)
			n = $urandom_range(1, dmaj);
		else if (kind >= 8 && r < 35)
			n = n + $urandom_range(1, 2);
		send_beat(REQ_START, 9'(xs), 8'(ys), 9'(xe), 8'(ye), 16'($urandom_range(65535)));
		step_n(n);
	endtask

	initial begin
		bit paused, held;
		sb = new();
		paused = 1'b0;
		held = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 10;
		recv_idle = 10;
		write_base(32'h0000_0000);
		step_n(1);
		send_beat(REQ_START, 9'd0, 8'd0, 9'd0, 8'd0, 16'h0000);
		step_n(2);
		send_beat(REQ_START, 9'd511, 8'd255, 9'd511, 8'd255, 16'hFFFF);
		step_n(1);
		send_beat(REQ_START, 9'd0, 8'd0, 9'd511, 8'd255, 16'hA5A5);
		step_n(2);
		// replaces the active line; reversed endpoints, falling minor
		send_beat(REQ_START, 9'd511, 8'd0, 9'd0, 8'd255, 16'h5A5A);
		step_n(2);
		send_beat(REQ_START, 9'd5, 8'd0, 9'd0, 8'd255, 16'h1234);
		step_n(2);
		send_beat(REQ_START, 9'd0, 8'd255, 9'd3, 8'd250, 16'h8001);
		step_n(6);
		// |dx| == |dy| stays shallow
		send_beat(REQ_START, 9'd10, 8'd10, 9'd13, 8'd7, 16'h7FFE);
		step_n(5);

		send_idle = 24;
		recv_idle = 57;
		write_base(32'hFFFF_FFFF);
		useful = 0;
		while (useful < 650) begin
			if (!paused && useful >= 300) begin
				paused = 1'b1;
				wait_drained();
			end
			random_sequence();
		end

		send_idle = 57;
		recv_idle = 24;
		write_base($urandom);
		useful = 0;
		while (useful < 650)
			random_sequence();

		send_idle = 0;
		recv_idle = 0;
		write_base(32'h8000_0000);
		useful = 0;
		while (useful < 650) begin
			if (!held && useful >= 200) begin
				held = 1'b1;
				stall_hold <= 1'b1;
				fork
					begin
						repeat (60) @(posedge clk);
						stall_hold <= 1'b0;
					end
				join_none
			end
			random_sequence();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_ctrl.sv
hw/rtl/lpr_datapath.sv
hw/rtl/line_pixel_rasterizer.sv
verif/tb_top.sv
